// File: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 4;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int DVD_W     = DATA_W + FRAC_BITS;
   localparam int DCNT_W    = $clog2(DVD_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_GT       = 4'd4,
      CMD_LT       = 4'd5,
      CMD_GE       = 4'd6,
      CMD_LE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_INC      = 4'd10,
      CMD_DEC      = 4'd11,
      CMD_MIN      = 4'd12,
      CMD_MAX      = 4'd13,
      CMD_FROM_INT = 4'd14,
      CMD_TO_INT   = 4'd15
   } cmd_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic                     is_div;
      logic                     dz;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Request channel: drive req_command/req_operand_a/req_operand_b and raise
// req_push; a beat is taken on a clock edge with req_push high and req_full
// low. Response channel: while rsp_empty is low the oldest result is on the
// rsp_ ports; raise rsp_pop to take the beat.
// All commands but a div with a nonzero divisor pass through the queue, stage
// one and the response register; mul as well (its product is registered, the shift follows).
// Throughput: one beat per cycle for all commands but div, while the
// receiver keeps taking results. A div with a nonzero divisor runs through
// a bit-serial divider, and the next item leaves the queue only once the
// divider has handed its quotient to stage one; items behind it wait in a
// four-entry queue, so requests keep flowing until that queue fills.
// Results always leave in request order.
// Reset (synchronous, active high) empties the queue and the pipeline.
// When the receiver holds off rsp_pop the pipeline holds, the queue fills
// and req_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module fixed_point_alu (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [fpa_pkg::CMD_W-1:0]         req_command,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_raw,
   output logic                              rsp_compare_true,
   output logic                              rsp_divide_by_zero
);
   import fpa_pkg::*;

   qstat_type qstat;
   item_type  q_item, q_head;
   logic      q_push, q_pop;

   fpa_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .qstat         (qstat),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   fpa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_item (q_item),
      .q_pop  (q_pop),
      .q_head (q_head),
      .qstat  (qstat)
   );

   fpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .qstat              (qstat),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_raw     (rsp_result_raw),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// File: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Accepts request beats, decodes the command and flags divides.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [fpa_pkg::CMD_W-1:0]     req_command,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   input  fpa_pkg::qstat_type            qstat,
   output logic                          q_push,
   output fpa_pkg::item_type             q_item
);
   import fpa_pkg::*;

   cmd_type cmd;

   always_comb begin
      cmd            = cmd_type'(req_command);
      q_item.cmd     = cmd;
      q_item.a       = req_operand_a;
      q_item.b       = req_operand_b;
      q_item.is_div  = (cmd == CMD_DIV);
      q_item.dz      = (cmd == CMD_DIV) && (req_operand_b == '0);
   end

   assign req_full = qstat.full;
   assign q_push   = req_push && !qstat.full;

endmodule

// File: hdl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO of decoded items between front and back.
// ----------------------------------------------------------------------------
module fpa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  fpa_pkg::item_type  q_item,
   input  logic               q_pop,
   output fpa_pkg::item_type  q_head,
   output fpa_pkg::qstat_type qstat
);
   import fpa_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = q_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = q_pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (q_push && !q_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!q_push && q_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ff] <= q_item;
      end
   end

   assign q_head      = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (cnt_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !q_push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !q_pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (cnt_ff == $past(cnt_ff) + QCNT_W'(1)))
      else $error("queue count slip");

endmodule

// File: hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Executes queued items: combinational ops, registered multiply, serial divide.
// ----------------------------------------------------------------------------
module fpa_back (
   input  logic                     clock,
   input  logic                     reset,
   input  fpa_pkg::item_type        q_head,
   input  fpa_pkg::qstat_type       qstat,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_raw,
   output logic                     rsp_compare_true,
   output logic                     rsp_divide_by_zero
);
   import fpa_pkg::*;

   div_state_type              dstate_ff, dstate_in;
   logic [DATA_W-1:0]          rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DVD_W-1:0]           quo_ff, quo_in;
   logic [DCNT_W-1:0]          dcnt_ff, dcnt_in;
   logic                       neg_ff, neg_in;
   logic                       div_idle, div_done;

   logic                       s1_v_ff, s1_v_in, s1_cmp_ff, s1_dz_ff, s1_mul_ff;
   logic [DATA_W-1:0]          s1_res_ff;
   logic signed [2*DATA_W-1:0] s1_prod_ff;
   logic                       rsp_v_ff, rsp_v_in;
   logic [DATA_W-1:0]          rsp_res_ff;
   logic                       rsp_cmp_ff, rsp_dz_ff;

   logic                       s2_free, s1_free, take, start, s1_load, s2_load;
   logic [DATA_W-1:0]          res_c, amag, bmag;
   logic                       cmp_c, lt, gt;
   logic [DATA_W:0]            rem_sh;
   logic                       ge;
   logic [DVD_W-1:0]           qsigned;
   logic signed [2*DATA_W-1:0] prod_sh;

   assign s2_free = !rsp_v_ff || rsp_pop;
   assign s1_free = !s1_v_ff || s2_free;
   assign take    = !qstat.empty && div_idle &&
                    ((q_head.is_div && !q_head.dz) || s1_free);
   assign start   = take && q_head.is_div && !q_head.dz;
   assign q_pop   = take;
   assign s1_load = (take && !start) || (div_done && s1_free);
   assign s2_load = s1_v_ff && s2_free;

   assign lt = (q_head.a < q_head.b);
   assign gt = (q_head.a > q_head.b);

   always_comb begin
      res_c = '0;
      cmp_c = 1'b0;
      unique case (q_head.cmd)
         CMD_ADD:      res_c = q_head.a + q_head.b;
         CMD_SUB:      res_c = q_head.a - q_head.b;
         CMD_MUL:      res_c = '0;
         CMD_DIV:      res_c = '0;
         CMD_GT:       cmp_c = gt;
         CMD_LT:       cmp_c = lt;
         CMD_GE:       cmp_c = !lt;
         CMD_LE:       cmp_c = !gt;
         CMD_EQ:       cmp_c = (q_head.a == q_head.b);
         CMD_NE:       cmp_c = (q_head.a != q_head.b);
         CMD_INC:      res_c = q_head.a + DATA_W'(1);
         CMD_DEC:      res_c = q_head.a - DATA_W'(1);
         CMD_MIN:      res_c = lt ? q_head.a : q_head.b;
         CMD_MAX:      res_c = gt ? q_head.a : q_head.b;
         CMD_FROM_INT: res_c = q_head.a <<< FRAC_BITS;
         CMD_TO_INT:   res_c = q_head.a >>> FRAC_BITS;
      endcase
   end

   // divider: next state
   always_comb begin
      dstate_in = dstate_ff;
      unique case (dstate_ff)
         DIV_IDLE: if (start) dstate_in = DIV_RUN;
         DIV_RUN:  if (dcnt_ff == DCNT_W'(DVD_W - 1)) dstate_in = DIV_DONE;
         DIV_DONE: if (s1_free) dstate_in = DIV_IDLE;
         default:  dstate_in = DIV_IDLE;
      endcase
   end

   // divider: outputs
   always_comb begin
      div_idle = 1'b0;
      div_done = 1'b0;
      unique case (dstate_ff)
         DIV_IDLE: div_idle = 1'b1;
         DIV_RUN:  ;
         DIV_DONE: div_done = 1'b1;
         default:  ;
      endcase
   end

   assign amag   = q_head.a[DATA_W-1] ? DATA_W'(-q_head.a) : DATA_W'(q_head.a);
   assign bmag   = q_head.b[DATA_W-1] ? DATA_W'(-q_head.b) : DATA_W'(q_head.b);
   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      dcnt_in = dcnt_ff;
      neg_in  = neg_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = DVD_W'(amag) << FRAC_BITS;
         dvs_in  = bmag;
         dcnt_in = '0;
         neg_in  = q_head.a[DATA_W-1] ^ q_head.b[DATA_W-1];
      end else if (dstate_ff == DIV_RUN) begin
         rem_in  = ge ? DATA_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DATA_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   assign qsigned = neg_ff ? DVD_W'(-quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= DIV_IDLE;
      end else begin
         dstate_ff <= dstate_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      dcnt_ff <= dcnt_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (s1_load) begin
         s1_v_in = 1'b1;
      end else if (s2_load) begin
         s1_v_in = 1'b0;
      end
      rsp_v_in = rsp_v_ff;
      if (s2_load) begin
         rsp_v_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         if (div_done) begin
            s1_res_ff <= qsigned[DATA_W-1:0];
            s1_cmp_ff <= 1'b0;
            s1_dz_ff  <= 1'b0;
            s1_mul_ff <= 1'b0;
         end else begin
            s1_res_ff <= res_c;
            s1_cmp_ff <= cmp_c;
            s1_dz_ff  <= q_head.dz;
            s1_mul_ff <= (q_head.cmd == CMD_MUL);
         end
         s1_prod_ff <= q_head.a * q_head.b;
      end
   end

   assign prod_sh = s1_prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_res_ff <= s1_mul_ff ? prod_sh[DATA_W-1:0] : s1_res_ff;
         rsp_cmp_ff <= s1_cmp_ff;
         rsp_dz_ff  <= s1_dz_ff;
      end
   end

   assign rsp_empty          = !rsp_v_ff;
   assign rsp_result_raw     = rsp_res_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      !div_idle |-> !q_pop) else $error("queue read while divider busy");
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s2_free) |-> !s1_load) else $error("stage one overwritten");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && (rsp_dz_ff || rsp_cmp_ff)) |-> (rsp_res_ff == '0))
      else $error("flagged result not zero");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      start |=> (dstate_ff == DIV_RUN)) else $error("divider failed to start");

endmodule
